// ----- hdl/ddo_pkg.sv -----
package ddo_pkg;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } ddo_in_t;

  typedef struct packed {
    logic signed [63:0] x_position;
    logic signed [63:0] y_position;
    logic        [47:0] heading_angle;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] forward_speed;
    logic signed [31:0] turn_rate;
  } ddo_out_t;

  typedef enum logic [1:0] {
    REG_ODOM = 2'd0,
    REG_TURN = 2'd1,
    REG_VEL  = 2'd2,
    REG_SPIN = 2'd3
  } cfg_reg_e;

  localparam logic [31:0] ODOM_RESET = 32'd1683930;
  localparam logic [31:0] TURN_RESET = 32'd171525000;
  localparam logic [31:0] VEL_RESET  = 32'd274077;
  localparam logic [31:0] SPIN_RESET = 32'd685192;

  // CORDIC: Q4.30 trig with pre-compensated gain, angles 2^32 per turn
  localparam int TRIG_W     = 34;
  localparam int STEP_W     = 6;
  localparam int ATAN_DEPTH = 40;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [0:ATAN_DEPTH-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  typedef enum logic [3:0] {
    MUL_NONE, MUL_HDG, MUL_TRAV, MUL_FWD, MUL_SPIN,
    MUL_XHI, MUL_XLO, MUL_YHI, MUL_YLO
  } mul_sel_e;

  typedef enum logic [3:0] {
    CAP_NONE, CAP_HDG, CAP_TRAV, CAP_FWD, CAP_SPIN,
    CAP_XHI, CAP_XLO, CAP_YHI, CAP_YLO
  } cap_sel_e;

  typedef enum logic [3:0] {
    S_IDLE, S_HDG, S_TRAV, S_FWD, S_SPIN, S_WAIT,
    S_XHI, S_XLO, S_YHI, S_YLO, S_YFIN, S_UPD
  } ctrl_state_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    cap_sel_e cap_sel;
    logic     cordic_start;
    logic     update;
  } ddo_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic out_busy;
  } ddo_status_t;

endpackage

// ----- hdl/ddo_stream_if.sv -----
interface ddo_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/ddo_cordic.sv -----
module ddo_cordic #(
  parameter int STEPS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [31:0]                         angle_i,
  output logic                                done_o,
  output logic signed [ddo_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [ddo_pkg::TRIG_W-1:0]   sin_o
);
  import ddo_pkg::*;

  localparam int N = (STEPS > ATAN_DEPTH) ? ATAN_DEPTH : ((STEPS < 0) ? 0 : STEPS);

  logic signed [TRIG_W-1:0] x_q, y_q, z_q, x_d, y_d, z_d, xs, ys, at;
  logic                     flip_q, busy_q;
  logic [STEP_W-1:0]        cnt_q;

  always_comb begin
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = $signed({2'b00, ATAN_TAB[cnt_q]});
    if (!z_q[TRIG_W-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= (N != 0);
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == STEP_W'(N - 1)) busy_q <= 1'b0;
    end
  end

  // outer half turn folded in by toggling the sign bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= angle_i[31] ^ angle_i[30];
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= (angle_i[31] ^ angle_i[30])
                ? TRIG_W'($signed({~angle_i[31], angle_i[30:0]}))
                : TRIG_W'($signed(angle_i));
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = !busy_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

// ----- hdl/ddo_datapath.sv -----
module ddo_datapath #(
  parameter int STEPS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  ddo_pkg::ddo_in_t    in_data_i,
  input  ddo_pkg::ddo_cmd_t   cmd_i,
  output ddo_pkg::ddo_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ddo_pkg::ddo_out_t   out_data_o
);
  import ddo_pkg::*;

  logic [31:0] odom_q, turn_q, vel_q, spin_q;

  logic [32:0] dmag_q, smag_q;
  logic        dneg_q, sneg_q;
  logic [16:0] fmag_q, tmag_q;
  logic        fneg_q, tneg_q;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod_q;

  logic [47:0] hdg_q, hdg_new_q, hdelta;
  logic [55:0] travel_q;
  logic signed [31:0] fwd_q, rate_q;
  logic [63:0] xpart_q, ypart_q;
  logic signed [63:0] x_q, y_q, xmove, ymove;

  logic signed [TRIG_W-1:0] c1, s1, c2, s2;
  logic        done1, done2;
  logic [31:0] cmag, smag_t;

  logic signed [32:0] d_w, s_w;
  logic signed [16:0] f_w, t_w;

  ddo_out_t out_q;
  logic     out_valid_q;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t[64] != t[63]) return t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return t[63:0];
  endfunction

  function automatic logic signed [31:0] sat_speed(input logic [48:0] m, input logic neg);
    if (neg) begin
      if (m > 49'h80000000) return 32'sh80000000;
      return -$signed(m[31:0]);
    end
    if (m > 49'h7FFFFFFF) return 32'sh7FFFFFFF;
    return $signed(m[31:0]);
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W:0]    t;
    logic signed [TRIG_W-15:0] r;
    t = {v[TRIG_W-1], v} + (TRIG_W+1)'(16384);
    r = (TRIG_W-14)'(t >>> 15);
    if (r > 32767)  return 16'sh7FFF;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odom_q <= ODOM_RESET;
      turn_q <= TURN_RESET;
      vel_q  <= VEL_RESET;
      spin_q <= SPIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ODOM: odom_q <= cfg_data_i;
        REG_TURN: turn_q <= cfg_data_i;
        REG_VEL:  vel_q  <= cfg_data_i;
        REG_SPIN: spin_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // mirrored left wheel: travel from right-left, turn from right+left
  assign d_w = {in_data_i.right_count[31], in_data_i.right_count}
             - {in_data_i.left_count[31], in_data_i.left_count};
  assign s_w = {in_data_i.right_count[31], in_data_i.right_count}
             + {in_data_i.left_count[31], in_data_i.left_count};
  assign f_w = {in_data_i.right_speed[15], in_data_i.right_speed}
             - {in_data_i.left_speed[15], in_data_i.left_speed};
  assign t_w = {in_data_i.right_speed[15], in_data_i.right_speed}
             + {in_data_i.left_speed[15], in_data_i.left_speed};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dneg_q <= d_w[32];
      dmag_q <= d_w[32] ? 33'(-d_w) : 33'(d_w);
      sneg_q <= s_w[32];
      smag_q <= s_w[32] ? 33'(-s_w) : 33'(s_w);
      fneg_q <= f_w[16];
      fmag_q <= f_w[16] ? 17'(-f_w) : 17'(f_w);
      tneg_q <= t_w[16];
      tmag_q <= t_w[16] ? 17'(-t_w) : 17'(t_w);
    end
  end

  assign cmag   = c1[TRIG_W-1] ? 32'(-c1) : 32'(c1);
  assign smag_t = s1[TRIG_W-1] ? 32'(-s1) : 32'(s1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_HDG:  begin mul_a = smag_q;                      mul_b = turn_q; end
      MUL_TRAV: begin mul_a = dmag_q;                      mul_b = odom_q; end
      MUL_FWD:  begin mul_a = {16'd0, fmag_q};             mul_b = vel_q;  end
      MUL_SPIN: begin mul_a = {16'd0, tmag_q};             mul_b = spin_q; end
      MUL_XHI:  begin mul_a = {9'd0, travel_q[55:32]};     mul_b = cmag;   end
      MUL_XLO:  begin mul_a = {1'b0, travel_q[31:0]};      mul_b = cmag;   end
      MUL_YHI:  begin mul_a = {9'd0, travel_q[55:32]};     mul_b = smag_t; end
      MUL_YLO:  begin mul_a = {1'b0, travel_q[31:0]};      mul_b = smag_t; end
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != MUL_NONE) prod_q <= {32'd0, mul_a} * {33'd0, mul_b};
  end

  assign hdelta = sneg_q ? (48'd0 - prod_q[47:0]) : prod_q[47:0];

  always_ff @(posedge clk_i) begin
    case (cmd_i.cap_sel)
      CAP_HDG:  hdg_new_q <= hdg_q + hdelta;
      CAP_TRAV: travel_q  <= prod_q[64:9];
      CAP_FWD:  fwd_q     <= sat_speed({1'b0, prod_q[64:17]}, fneg_q);
      CAP_SPIN: rate_q    <= sat_speed(prod_q[64:16], tneg_q);
      CAP_XHI:  xpart_q   <= {prod_q[61:0], 2'b00};
      CAP_XLO:  xpart_q   <= xpart_q + {29'd0, prod_q[64:30]};
      CAP_YHI:  ypart_q   <= {prod_q[61:0], 2'b00};
      CAP_YLO:  ypart_q   <= ypart_q + {29'd0, prod_q[64:30]};
      default:  ;
    endcase
  end

  assign xmove = (dneg_q != c1[TRIG_W-1]) ? -$signed(xpart_q) : $signed(xpart_q);
  assign ymove = (dneg_q != s1[TRIG_W-1]) ? -$signed(ypart_q) : $signed(ypart_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      hdg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.update) begin
        x_q         <= sat_add(x_q, xmove);
        y_q         <= sat_add(y_q, ymove);
        hdg_q       <= hdg_new_q;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_q.x_position    <= sat_add(x_q, xmove);
      out_q.y_position    <= sat_add(y_q, ymove);
      out_q.heading_angle <= hdg_new_q;
      out_q.quat_z        <= to_q15(s2);
      out_q.quat_w        <= to_q15(c2);
      out_q.forward_speed <= fwd_q;
      out_q.turn_rate     <= rate_q;
    end
  end

  // pose cordic on old heading, quaternion cordic on new half heading
  ddo_cordic #(.STEPS(STEPS)) u_pose_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .angle_i (hdg_q[47:16]),
    .done_o  (done1),
    .cos_o   (c1),
    .sin_o   (s1)
  );

  ddo_cordic #(.STEPS(STEPS)) u_quat_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .angle_i ({1'b0, hdg_new_q[47:17]}),
    .done_o  (done2),
    .cos_o   (c2),
    .sin_o   (s2)
  );

  assign status_o.cordic_done = done1 && done2;
  assign status_o.out_busy    = out_valid_q && !out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign out_data_o           = out_q;

endmodule

// ----- hdl/ddo_ctrl.sv -----
module ddo_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ddo_pkg::ddo_status_t status_i,
  output ddo_pkg::ddo_cmd_t    cmd_o
);
  import ddo_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d            = state_q;
    in_ready_o         = 1'b0;
    cmd_o.load         = 1'b0;
    cmd_o.mul_sel      = MUL_NONE;
    cmd_o.cap_sel      = CAP_NONE;
    cmd_o.cordic_start = 1'b0;
    cmd_o.update       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HDG;
        end
      end
      S_HDG: begin
        cmd_o.mul_sel = MUL_HDG;
        state_d       = S_TRAV;
      end
      S_TRAV: begin
        cmd_o.mul_sel = MUL_TRAV;
        cmd_o.cap_sel = CAP_HDG;
        state_d       = S_FWD;
      end
      S_FWD: begin
        cmd_o.mul_sel = MUL_FWD;
        cmd_o.cap_sel = CAP_TRAV;
        state_d       = S_SPIN;
      end
      S_SPIN: begin
        cmd_o.mul_sel      = MUL_SPIN;
        cmd_o.cap_sel      = CAP_FWD;
        cmd_o.cordic_start = 1'b1;
        state_d            = S_WAIT;
      end
      S_WAIT: begin
        cmd_o.cap_sel = CAP_SPIN;
        if (status_i.cordic_done) state_d = S_XHI;
      end
      S_XHI: begin
        cmd_o.mul_sel = MUL_XHI;
        state_d       = S_XLO;
      end
      S_XLO: begin
        cmd_o.mul_sel = MUL_XLO;
        cmd_o.cap_sel = CAP_XHI;
        state_d       = S_YHI;
      end
      S_YHI: begin
        cmd_o.mul_sel = MUL_YHI;
        cmd_o.cap_sel = CAP_XLO;
        state_d       = S_YLO;
      end
      S_YLO: begin
        cmd_o.mul_sel = MUL_YLO;
        cmd_o.cap_sel = CAP_YHI;
        state_d       = S_YFIN;
      end
      S_YFIN: begin
        cmd_o.cap_sel = CAP_YLO;
        state_d       = S_UPD;
      end
      S_UPD: begin
        if (!status_i.out_busy) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_no_update_over_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> !status_i.out_busy)
    else $error("result overwritten while output word pending");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_HDG)
    else $error("accepted word did not start the sequence");

  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT && !status_i.cordic_done) |=> state_q == S_WAIT)
    else $error("left cordic wait before both units finished");

endmodule

// ----- hdl/diff_drive_odometry.sv -----
// Each input word passes through load, the scalar multiplies, the CORDIC pair, the x/y
//   multiplies and the commit before its output word is valid.
// A new input word is taken only once the last one is committed, since the iterative
//   CORDIC pair and the shared 33x32 multiplier sequence serve one word at a time.
// The output register lets the next input word in while a result waits.
// Reset (async, active low) clears pose, heading and control, and loads the
//   default factors; no clearing pass is needed.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  ddo_stream_if.sink   in_i,
  ddo_stream_if.source out_o
);
  import ddo_pkg::*;

  // command/status between sequencer and datapath
  ddo_cmd_t    cmd;
  ddo_status_t status;

  // Sequencer: load, four scalar multiplies (heading, travel, two speeds),
  // then wait on both CORDICs, four multiplies for the x/y moves, commit.
  ddo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: factor registers, shared multiplier, pose accumulators
  // (saturating x/y, wrapping 48-bit heading) and the output register.
  ddo_datapath #(.STEPS(CORDIC_STEPS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

// ----- test/ddo_checker.sv -----
`timescale 1ns / 1ps
module ddo_checker
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  ddo_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  ddo_out_t    out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          seen_o
);

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  logic [31:0] odom_f, turn_f, vel_f, spin_f;
  logic signed [63:0] x_acc, y_acc;
  logic [47:0] hdg_acc;
  ddo_out_t pose_q[$];

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] sra(input logic signed [63:0] v, input int s);
    return v >>> s;
  endfunction

  task automatic sincos(input logic [31:0] ang, output logic signed [63:0] c,
                        output logic signed [63:0] s);
    logic signed [63:0] z, x, y, xs, ys;
    logic flip;
    int n;
    z = 64'(signed'(ang));
    x = 64'(CORDIC_GAIN);
    y = 0;
    n = CORDIC_STEPS > 40 ? 40 : (CORDIC_STEPS < 0 ? 0 : CORDIC_STEPS);
    flip = (z >= 64'sd1073741824) || (z < -64'sd1073741824);
    if (flip) z = (z >= 0) ? z - 64'sd2147483648 : z + 64'sd2147483648;
    for (int i = 0; i < n; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= 64'(ATAN_TAB[i]);
      end else begin
        x += ys; y -= xs; z += 64'(ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic signed [63:0] move(input logic signed [63:0] d,
      input logic [63:0] trav, input logic signed [63:0] trig);
    logic [127:0] p;
    logic [63:0] m;
    p = {64'd0, trav} * {64'd0, mag(trig) & 64'hFFFF_FFFF};
    m = p[93:30];
    return ((d < 0) != (trig < 0)) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] r;
    r = 65'(a) + 65'(b);
    if (r > 65'(S64_MAX)) return S64_MAX;
    if (r < 65'(S64_MIN)) return S64_MIN;
    return r[63:0];
  endfunction

  function automatic logic signed [31:0] speed(input logic signed [63:0] v,
                                               input logic [31:0] f, input int sh);
    logic [63:0] m;
    m = (mag(v) * {32'd0, f}) >> sh;
    if (v < 0) return m > 64'h8000_0000 ? 32'sh8000_0000 : -$signed(m[31:0]);
    return m > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : m[31:0];
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic predict_pose(input ddo_in_t w);
    logic signed [63:0] d, sm, c, s, qc, qs;
    logic [63:0] trav;
    ddo_out_t e;
    d = 64'(w.right_count) - 64'(w.left_count);
    sm = 64'(w.right_count) + 64'(w.left_count);
    trav = (mag(d) * {32'd0, odom_f}) >> 9;
    sincos(hdg_acc[47:16], c, s);
    x_acc = sat_sum(x_acc, move(d, trav, c));
    y_acc = sat_sum(y_acc, move(d, trav, s));
    hdg_acc = hdg_acc + 48'(sm * $signed({32'd0, turn_f}));
    sincos({1'b0, hdg_acc[47:17]}, qc, qs);
    e.x_position = x_acc;
    e.y_position = y_acc;
    e.heading_angle = hdg_acc;
    e.quat_z = q15(qs);
    e.quat_w = q15(qc);
    e.forward_speed = speed(64'(w.right_speed) - 64'(w.left_speed), vel_f, 17);
    e.turn_rate = speed(64'(w.right_speed) + 64'(w.left_speed), spin_f, 16);
    pose_q.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ddo_out_t e;
    logic bad;
    if (!rst_ni) begin
      odom_f <= ODOM_RESET; turn_f <= TURN_RESET;
      vel_f <= VEL_RESET; spin_f <= SPIN_RESET;
      x_acc = 0; y_acc = 0; hdg_acc = 0;
      fail_count_o <= 0; seen_o <= 0;
      pose_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ODOM: odom_f <= cfg_data_i;
          REG_TURN: turn_f <= cfg_data_i;
          REG_VEL:  vel_f  <= cfg_data_i;
          REG_SPIN: spin_f <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_pose(in_data_i);
      if (out_valid_i && out_ready_i) begin
        seen_o <= seen_o + 1;
        if (pose_q.size() == 0) begin
          $error("output word with no prediction waiting");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = pose_q.pop_front();
          bad = 0;
          if (e.x_position !== out_data_i.x_position) begin
            $error("x_position expected %0d got %0d", e.x_position, out_data_i.x_position);
            bad = 1;
          end
          if (e.y_position !== out_data_i.y_position) begin
            $error("y_position expected %0d got %0d", e.y_position, out_data_i.y_position);
            bad = 1;
          end
          if (e.heading_angle !== out_data_i.heading_angle) begin
            $error("heading_angle expected %0d got %0d", e.heading_angle,
                   out_data_i.heading_angle);
            bad = 1;
          end
          if (e.quat_z !== out_data_i.quat_z) begin
            $error("quat_z expected %0d got %0d", e.quat_z, out_data_i.quat_z);
            bad = 1;
          end
          if (e.quat_w !== out_data_i.quat_w) begin
            $error("quat_w expected %0d got %0d", e.quat_w, out_data_i.quat_w);
            bad = 1;
          end
          if (e.forward_speed !== out_data_i.forward_speed) begin
            $error("forward_speed expected %0d got %0d", e.forward_speed,
                   out_data_i.forward_speed);
            bad = 1;
          end
          if (e.turn_rate !== out_data_i.turn_rate) begin
            $error("turn_rate expected %0d got %0d", e.turn_rate, out_data_i.turn_rate);
            bad = 1;
          end
          if (bad) fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

  assign pending_o = pose_q.size();

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import ddo_pkg::*;

  localparam int STEPS    = 24;
  localparam int LATENCY  = STEPS + 11;
  localparam int WATCHDOG = 2000;
  localparam int N_RANDOM = 2000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending, seen;
  int          idle_cnt;
  int          words_sent;
  bit          timed_out;

  ddo_stream_if #(.payload_t(ddo_in_t))  in_if ();
  ddo_stream_if #(.payload_t(ddo_out_t)) out_if ();

  always #5 clk_i = ~clk_i;

  diff_drive_odometry #(.CORDIC_STEPS(STEPS)) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_if), .out_o(out_if)
  );

  ddo_checker #(.CORDIC_STEPS(STEPS)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_if.valid), .in_ready_i(in_if.ready), .in_data_i(in_if.data),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data),
    .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen)
  );

  initial begin
    in_if.valid = 0;
    in_if.data = '0;
    out_if.ready = 0;
  end

  // Sink side: after each word, may drop ready for a random gap; calm stretches keep it high.
  bit sink_calm;
  int sink_wait = 0;
  int sink_gap;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) sink_calm <= ~sink_calm;
      if (out_if.valid && out_if.ready) begin
        sink_gap = sink_calm ? 0 : $urandom_range(0, 7);
        sink_wait <= sink_gap;
        out_if.ready <= (sink_gap == 0);
      end else if (sink_wait > 0) begin
        sink_wait <= sink_wait - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no accepted word on either channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG);
      $display("diff_drive_odometry test failed");
      $finish;
    end
  end

  bit src_calm;

  // valid stays high across back-to-back words; drain() drops it
  task automatic send_word(input ddo_in_t w);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // drain everything, then let the block settle before touching registers
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [31:0] o, input logic [31:0] t,
                           input logic [31:0] v, input logic [31:0] s);
    write_reg(REG_ODOM, o);
    write_reg(REG_TURN, t);
    write_reg(REG_VEL, v);
    write_reg(REG_SPIN, s);
    cfg_we_i <= 1'b0;
  endtask

  function automatic ddo_in_t mk(input logic [31:0] lc, input logic [31:0] rc,
                                 input logic [15:0] ls, input logic [15:0] rs);
    ddo_in_t w;
    w.left_count = lc; w.right_count = rc;
    w.left_speed = ls; w.right_speed = rs;
    return w;
  endfunction

  // mostly realistic small increments, some full-range words
  function automatic ddo_in_t rand_word();
    ddo_in_t w;
    if ($urandom_range(0, 3) == 0) begin
      w = mk($urandom, $urandom, 16'($urandom), 16'($urandom));
    end else begin
      w.left_count  = $signed($urandom_range(0, 4000)) - 2000;
      w.right_count = $signed($urandom_range(0, 4000)) - 2000;
      w.left_speed  = 16'($signed($urandom_range(0, 2000)) - 1000);
      w.right_speed = 16'($signed($urandom_range(0, 2000)) - 1000);
    end
    return w;
  endfunction

  task automatic rand_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) == 0) src_calm = ~src_calm;
      send_word(rand_word());
    end
  endtask

  initial begin
    timed_out = 0;
    src_calm = 0;
    sink_calm = 0;
    words_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset factors, zero motion, field extremes, heading wrap.
    send_word(mk(0, 0, 0, 0));
    send_word(mk(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF));
    send_word(mk(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000));
    send_word(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_word(mk(1000, 1000, 100, 100));
    send_word(mk(-1000, 1000, 16'(-100), 100));
    // pause: wait for every result before the next word
    drain();

    // Max factors: position saturation, speed saturation.
    write_all('1, '1, '1, '1);
    for (int i = 0; i < 8; i++)
      send_word(mk(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF));
    send_word(mk(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000));
    send_word(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF));
    send_word(mk(32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000));
    drain();

    // Zero factors: no motion at all.
    write_all(0, 0, 0, 0);
    send_word(mk(32'h1234_5678, 32'hDEAD_BEEF, 16'h5A5A, 16'hA5A5));
    send_word(mk(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF));
    drain();

    // Heading steps to hit half and quarter turns (quaternion near one).
    write_all(ODOM_RESET, 32'h8000_0000, VEL_RESET, SPIN_RESET);
    for (int i = 0; i < 6; i++) send_word(mk(0, 32'h0000_4000, 0, 0));
    drain();

    // Random phases over several factor settings.
    write_all(ODOM_RESET, TURN_RESET, VEL_RESET, SPIN_RESET);
    rand_phase(N_RANDOM / 4);
    drain();
    write_all($urandom, $urandom, $urandom, $urandom);
    rand_phase(N_RANDOM / 4);
    drain();
    write_all('1, $urandom, '1, $urandom);
    rand_phase(N_RANDOM / 4);
    drain();
    write_all($urandom_range(0, 1 << 24), $urandom, $urandom_range(0, 1 << 20),
              $urandom_range(0, 1 << 20));
    rand_phase(N_RANDOM / 4);

    drain();
    $display("sent %0d input words over eight factor settings, checked %0d results",
             words_sent, seen);
    $display("covered extremes, saturation, zero factors and heading wrap");
    if (fail_count == 0) begin
      $display("diff_drive_odometry test passed");
    end else begin
      $display("diff_drive_odometry test failed");
    end
    $finish;
  end

endmodule
